// File: src/frame_rate_meter_macros.svh
// Assertion helpers for the frame rate meter.
`ifndef FRAME_RATE_METER_MACROS_SVH
`define FRAME_RATE_METER_MACROS_SVH

// same-cycle implication
`define FRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/frm_pkg.sv
package frm_pkg;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned RATE_W   = 24;
	localparam int unsigned FRAC_W   = 8;
	localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;
	localparam logic [9:0]  SCALE    = 10'd1000;
	localparam logic [3:0]  BIAS     = 4'd10;
	localparam logic [DATA_W-1:0] WIN_RESET = 16'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_NUM,
		ST_DIVF,
		ST_DIVT,
		ST_DONE
	} frm_state_t;
endpackage

// File: src/frm_if.sv
interface frm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [15:0] frame_time_ms;
	logic [15:0] tick_count;
	modport source (output valid, now_ms, frame_time_ms, tick_count, input ready);
	modport sink   (input valid, now_ms, frame_time_ms, tick_count, output ready);
endinterface

interface frm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] fps;
	logic [23:0] feels_like_fps;
	logic [23:0] tick_rate;
	logic        window_closed;
	modport source (output valid, fps, feels_like_fps, tick_rate, window_closed, input ready);
	modport sink   (input valid, fps, feels_like_fps, tick_rate, window_closed, output ready);
endinterface

interface frm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] window_ms;
	modport source (output valid, window_ms, input ready);
	modport sink   (input valid, window_ms, output ready);
endinterface

// File: src/frm_trace_mem.sv
module frm_trace_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [frm_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [frm_pkg::DATA_W-1:0] rdata
);
	import frm_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] data_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_q <= mem[raddr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? data_q : '0;
endmodule

// File: src/frm_div.sv
module frm_div #(
	parameter int unsigned NW = 42,
	parameter int unsigned DW = 38
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	output logic                       done,
	output logic [frm_pkg::RATE_W-1:0] quo
);
	import frm_pkg::*;

	localparam int unsigned QW = RATE_W;
	localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;
	localparam int unsigned SW = $clog2(QW + 1);

	logic [RW-1:0] rem_q, dsh_q, full_den;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          run_q, done_q, ge;

	assign full_den = RW'(den) << QW;
	assign ge       = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(num);
			dsh_q <= RW'(den) << (QW - 1);
			quo_q <= (den == '0 || RW'(num) >= full_den) ? RATE_MAX : '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || RW'(num) >= full_den) begin
					done_q <= 1'b1;
				end else begin
					run_q  <= 1'b1;
					step_q <= SW'(QW);
				end
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// File: src/frame_rate_meter.sv
// Frame rate meter. Each input item reports one finished frame; exactly one
// result item comes back per input item. An item that does not close the
// measurement window passes through the done state to the result register.
// For an item that closes the window, both trace memories are read one entry
// a cycle to form the sum and the sum of squares, then one shared restoring
// divider yields 24 quotient bits, one bit a cycle, for the frame figure and
// then for the tick figure. Traces live in two single-port-write memories
// used as circular buffers; entries never written read as zero. The result
// register lets the next item enter while a result waits. window_ms is
// written through the cfg channel, which is always ready; write it only while
// the block is idle.
module frame_rate_meter #(
	parameter int unsigned TRACE_LEN = 32
) (
	input logic      clk,
	input logic      arst_n,
	frm_in_if.sink   item_in,
	frm_out_if.source result_out,
	frm_cfg_if.sink  cfg
);
	import frm_pkg::*;

	localparam int unsigned AW  = (TRACE_LEN > 1) ? $clog2(TRACE_LEN) : 1;
	localparam int unsigned CW  = $clog2(TRACE_LEN + 3);
	localparam int unsigned LW  = $clog2(TRACE_LEN + 1);
	localparam int unsigned S1W = DATA_W + LW;
	localparam int unsigned S2W = 2 * DATA_W + LW;
	localparam int unsigned PW  = S1W + 10;
	localparam int unsigned NW  = PW + FRAC_W;

	frm_state_t state_q, state_d;

	// window and counters
	logic [DATA_W-1:0] window_q;
	logic [DATA_W-1:0] fcnt_q, fcnt_inc;
	logic [TIME_W-1:0] wstart_q, elapsed;
	logic              closes, in_acc, load_out;

	// item held while it is worked on
	logic [DATA_W-1:0] ft_q;
	logic              closed_q;

	// held figures
	logic [DATA_W-1:0] fps_hold_q;
	logic [RATE_W-1:0] feels_hold_q, tick_hold_q;

	// trace pointers and sweep
	logic [AW-1:0]     fptr_q, tptr_q, raddr;
	logic [CW-1:0]     cnt_q;
	logic              rv_s1, sv_s2;
	logic [DATA_W-1:0] rf, rt, wf_s2, wt_s2;
	logic [2*DATA_W-1:0] sqf_s2, sqt_s2;
	logic [S1W-1:0]    s1f_q, s1t_q;
	logic [S2W-1:0]    s2f_q, s2t_q;
	logic [NW-1:0]     numf_q, numt_q;

	// divider
	logic              div_start, div_done;
	logic [RATE_W-1:0] div_q;

	// result register
	logic              out_v_q, closed_out_q;
	logic [DATA_W-1:0] fps_out_q;
	logic [RATE_W-1:0] feels_out_q, tick_out_q;

	assign item_in.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_acc        = item_in.valid && item_in.ready;
	assign fcnt_inc      = (fcnt_q == '1) ? fcnt_q : fcnt_q + 1'b1;
	assign elapsed       = item_in.now_ms - wstart_q;
	assign closes        = elapsed >= TIME_W'(window_q);
	assign load_out      = (state_q == ST_DONE) && (!out_v_q || result_out.ready);
	assign raddr         = cnt_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = closes ? ST_SUM : ST_DONE;
				end
			end
			ST_SUM: begin
				if (cnt_q == CW'(TRACE_LEN + 2)) begin
					state_d = ST_NUM;
				end
			end
			ST_NUM: begin
				div_start = 1'b1;
				state_d   = ST_DIVF;
			end
			ST_DIVF: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIVT;
				end
			end
			ST_DIVT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// window bookkeeping taken at accept, plus cfg writes, held figures and trace pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WIN_RESET;
			fcnt_q       <= '0;
			wstart_q     <= '0;
			fps_hold_q   <= '0;
			feels_hold_q <= '0;
			tick_hold_q  <= '0;
			fptr_q       <= '0;
			tptr_q       <= '0;
			closed_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				window_q <= cfg.window_ms;
			end
			if (in_acc) begin
				closed_q <= closes;
				if (closes) begin
					fcnt_q     <= '0;
					wstart_q   <= item_in.now_ms;
					fps_hold_q <= fcnt_inc;
					tptr_q     <= (tptr_q == AW'(TRACE_LEN - 1)) ? '0 : tptr_q + 1'b1;
				end else begin
					fcnt_q <= fcnt_inc;
				end
			end
			if (state_q == ST_DIVF && div_done) begin
				feels_hold_q <= div_q;
			end
			if (state_q == ST_DIVT && div_done) begin
				tick_hold_q <= div_q;
			end
			if (load_out) begin
				fptr_q <= (fptr_q == AW'(TRACE_LEN - 1)) ? '0 : fptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ft_q <= item_in.frame_time_ms;
		end
	end

	// trace memories: tick count enters on close, frame time when the result is loaded
	frm_trace_mem #(.DEPTH(TRACE_LEN), .AW(AW)) u_ftmem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (load_out),
		.waddr (fptr_q),
		.wdata (ft_q),
		.raddr (raddr),
		.rdata (rf)
	);

	frm_trace_mem #(.DEPTH(TRACE_LEN), .AW(AW)) u_tkmem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (in_acc && closes),
		.waddr (tptr_q),
		.wdata (item_in.tick_count),
		.raddr (raddr),
		.rdata (rt)
	);

	// sweep: read, square, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			sv_s2 <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SUM) && (cnt_q < CW'(TRACE_LEN));
			sv_s2 <= rv_s1;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == ST_SUM) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wf_s2  <= rf;
		wt_s2  <= rt;
		sqf_s2 <= rf * rf;
		sqt_s2 <= rt * rt;
		if (in_acc) begin
			s1f_q <= '0;
			s1t_q <= '0;
			s2f_q <= '0;
			s2t_q <= '0;
		end else if (sv_s2) begin
			s1f_q <= s1f_q + S1W'(wf_s2);
			s1t_q <= s1t_q + S1W'(wt_s2);
			s2f_q <= s2f_q + S2W'(sqf_s2);
			s2t_q <= s2t_q + S2W'(sqt_s2);
		end
		// numerator (10 + 1000 * S1) in PW.8 fixed point
		numf_q <= {PW'(s1f_q) * PW'(SCALE) + PW'(BIAS), {FRAC_W{1'b0}}};
		numt_q <= {PW'(s1t_q) * PW'(SCALE) + PW'(BIAS), {FRAC_W{1'b0}}};
	end

	frm_div #(.NW(NW), .DW(S2W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ((state_q == ST_NUM) ? numf_q : numt_q),
		.den   ((state_q == ST_NUM) ? s2f_q : s2t_q),
		.done  (div_done),
		.quo   (div_q)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (result_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fps_out_q    <= fps_hold_q;
			feels_out_q  <= feels_hold_q;
			tick_out_q   <= tick_hold_q;
			closed_out_q <= closed_q;
		end
	end

	assign result_out.valid          = out_v_q;
	assign result_out.fps            = fps_out_q;
	assign result_out.feels_like_fps = feels_out_q;
	assign result_out.tick_rate      = tick_out_q;
	assign result_out.window_closed  = closed_out_q;
endmodule

// File: src/frm_checker.sv
`include "frame_rate_meter_macros.svh"

module frm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] fps,
	input logic [23:0] feels,
	input logic [23:0] tick,
	input logic        closed,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	`FRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fps) && $stable(feels) && $stable(tick) && $stable(closed), "result changed while stalled")
	`FRM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
	`FRM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg write refused")
	`FRM_ASSERT_NOW(a_out_after_work, $rose(out_valid), !$past(in_ready), "result without work")
endmodule

bind frame_rate_meter frm_checker u_frm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item_in.valid),
	.in_ready (item_in.ready),
	.out_valid(result_out.valid),
	.out_ready(result_out.ready),
	.fps      (result_out.fps),
	.feels    (result_out.feels_like_fps),
	.tick     (result_out.tick_rate),
	.closed   (result_out.window_closed),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready)
);

// File: tb/frm_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (src/frm_if.sv); this file holds the
// testbench-side item types shared by driver and checker.
package frm_tb_pkg;
	typedef struct packed {
		logic [31:0] now_ms;
		logic [15:0] frame_time_ms;
		logic [15:0] tick_count;
	} frame_item_t;

	typedef struct packed {
		logic [15:0] fps;
		logic [23:0] feels_like_fps;
		logic [23:0] tick_rate;
		logic        window_closed;
	} rate_item_t;
endpackage

// File: tb/tb_frame_rate_meter.sv
`timescale 1ns / 1ps
module tb_frame_rate_meter;
	import frm_pkg::*;
	import frm_tb_pkg::*;

	localparam int TRACE_LEN = 32;
	localparam int IDLE_PCT = 86;
	localparam int BOTH_PCT = 14;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	frm_in_if  item_if ();
	frm_out_if res_if ();
	frm_cfg_if cfg_if ();

	frame_rate_meter #(.TRACE_LEN(TRACE_LEN)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_if.sink),
		.result_out(res_if.source),
		.cfg       (cfg_if.sink)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Rate predictor: a private copy of the meter state
	// ---------------------------------------------------------------
	logic [15:0] win_len;
	logic [15:0] frame_cnt;
	logic [31:0] win_start;
	logic [15:0] ft_trace [TRACE_LEN];
	logic [15:0] tk_trace [TRACE_LEN];
	rate_item_t  held;

	rate_item_t  rate_expect_q[$];
	frame_item_t frame_pend_q[$];

	int errors = 0;
	int n_closed = 0;
	int n_checked = 0;
	int n_sat = 0;

	// 1000*(0.01+S1)/S2 in 16.8, saturating; S2 of zero saturates too
	function automatic logic [23:0] weighted_figure(input logic [15:0] t [TRACE_LEN]);
		longint unsigned s1, s2, q;
		s1 = 0;
		s2 = 0;
		for (int i = 0; i < TRACE_LEN; i++) begin
			s1 += t[i];
			s2 += longint'(t[i]) * t[i];
		end
		if (s2 == 0)
			return RATE_MAX;
		q = ((64'd10 + 64'd1000 * s1) * 64'd256) / s2;
		return (q > 64'hFFFFFF) ? RATE_MAX : q[23:0];
	endfunction

	task automatic predictor_reset();
		win_len = WIN_RESET;
		frame_cnt = '0;
		win_start = '0;
		for (int i = 0; i < TRACE_LEN; i++) begin
			ft_trace[i] = '0;
			tk_trace[i] = '0;
		end
		held = '0;
	endtask

	task automatic predict_frame(input frame_item_t it);
		rate_item_t r;
		if (frame_cnt != 16'hFFFF)
			frame_cnt++;
		r = held;
		r.window_closed = 1'b0;
		if (it.now_ms - win_start >= {16'd0, win_len}) begin
			win_start = it.now_ms;
			held.fps = frame_cnt;
			frame_cnt = '0;
			held.feels_like_fps = weighted_figure(ft_trace);
			for (int i = 1; i < TRACE_LEN; i++)
				tk_trace[i-1] = tk_trace[i];
			tk_trace[TRACE_LEN-1] = it.tick_count;
			held.tick_rate = weighted_figure(tk_trace);
			r = held;
			r.window_closed = 1'b1;
			n_closed++;
			if (held.feels_like_fps == RATE_MAX || held.tick_rate == RATE_MAX)
				n_sat++;
		end
		for (int i = 1; i < TRACE_LEN; i++)
			ft_trace[i-1] = ft_trace[i];
		ft_trace[TRACE_LEN-1] = it.frame_time_ms;
		rate_expect_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// Driver: offers queued frames; idles at random per phase
	// ---------------------------------------------------------------
	logic src_idle_en = 1'b0;
	logic snk_stall_en = 1'b0;
	int   idle_pct = IDLE_PCT;
	int   hold_off = 0;  // long receiver stall, counted in cycles
	logic drive_en = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.now_ms <= '0;
			item_if.frame_time_ms <= '0;
			item_if.tick_count <= '0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				predict_frame(frame_pend_q.pop_front());
			end
			// an offered item stays put until it is taken
			if (item_if.valid && !item_if.ready) begin
				item_if.valid <= 1'b1;
			end else if (drive_en && frame_pend_q.size() != 0 &&
				!(src_idle_en && $urandom_range(99) < idle_pct)) begin
				item_if.valid <= 1'b1;
				{item_if.now_ms, item_if.frame_time_ms, item_if.tick_count} <=
					frame_pend_q[0];
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// The head is only popped on a handshake and stays on the bus until then.

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= !(snk_stall_en && $urandom_range(99) < idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compares each result with the oldest expectation
	// ---------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (res_if.valid && res_if.ready) begin
				if (rate_expect_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					rate_item_t w;
					w = rate_expect_q.pop_front();
					n_checked++;
					if (res_if.fps !== w.fps)
						report_mismatch("fps", res_if.fps, w.fps);
					if (res_if.feels_like_fps !== w.feels_like_fps)
						report_mismatch("feels_like_fps", res_if.feels_like_fps,
							w.feels_like_fps);
					if (res_if.tick_rate !== w.tick_rate)
						report_mismatch("tick_rate", res_if.tick_rate, w.tick_rate);
					if (res_if.window_closed !== w.window_closed)
						report_mismatch("window_closed", res_if.window_closed,
							w.window_closed);
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
				$display("frame_rate_meter test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic [31:0] clock_ms;  // running millisecond time for random frames

	task automatic push_frame(input logic [31:0] now, input logic [15:0] ft,
		input logic [15:0] tc);
		frame_pend_q.push_back({now, ft, tc});
	endtask

	task automatic wait_drained();
		while (frame_pend_q.size() != 0 || rate_expect_q.size() != 0)
			@(posedge clk);
		// all results are taken by now; idle on before the next phase
		repeat (150) @(posedge clk);
	endtask

	task automatic write_window(input logic [15:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.window_ms <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		win_len = v;
	endtask

	// Random frames: time steps mostly small so windows close every few items
	task automatic random_frames(input int n);
		logic [15:0] ft;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: ft = 16'($urandom);
				1: ft = '0;
				2: ft = 16'hFFFF;
				default: ft = 16'($urandom_range(40));
			endcase
			if ($urandom_range(19) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(win_len / 2 + 8);
			push_frame(clock_ms, ft, ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($urandom_range(200)));
		end
	endtask

	initial begin
		predictor_reset();
		cfg_if.valid = 1'b0;
		cfg_if.window_ms = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_en <= 1'b1;

		// Directed: zero traces saturate, open window holds, wrap, extremes
		push_frame(32'd0, 16'd0, 16'd0);           // window open, held zeros
		push_frame(32'd999, 16'hFFFF, 16'hFFFF);
		push_frame(32'd1000, 16'd0, 16'd0);        // closes; zero tick sum
		push_frame(32'd1500, 16'd1, 16'd1);
		push_frame(32'd2000, 16'hFFFF, 16'hFFFF);  // closes
		push_frame(32'hFFFF_FFFF, 16'd1, 16'd5);   // huge difference closes
		push_frame(32'd500, 16'd1, 16'd0);         // wraps modulo 2^32
		push_frame(32'd999, 16'd1, 16'd3);         // closes exactly at window
		wait_drained();

		// window of zero: every item closes
		write_window(16'd0);
		for (int i = 0; i < 8; i++)
			push_frame($urandom, 16'(i), 16'hFFFF >> i);
		wait_drained();

		// largest window: frame counter climbs, then the window closes at 65535 ms
		write_window(16'hFFFF);
		push_frame(32'd70000, 16'd3, 16'd9);
		push_frame(32'd70001, 16'd3, 16'd9);
		push_frame(32'd135535, 16'd3, 16'd9);
		wait_drained();

		// Random phases over several window lengths and idle patterns
		clock_ms = 32'd200000;
		write_window(16'd1);
		random_frames(110);
		wait_drained();

		write_window(16'd60);
		src_idle_en <= 1'b1;
		random_frames(110);
		wait_drained();

		write_window(16'd1000);
		src_idle_en <= 1'b0;
		snk_stall_en <= 1'b1;
		random_frames(110);
		wait_drained();

		write_window(16'($urandom_range(1, 300)));
		src_idle_en <= 1'b1;
		idle_pct = BOTH_PCT;
		random_frames(110);
		wait_drained();

		// back-pressure: receiver holds off while the sender keeps offering
		write_window(16'd5);
		src_idle_en <= 1'b0;
		snk_stall_en <= 1'b0;
		idle_pct = IDLE_PCT;
		hold_off = 400;
		random_frames(110);
		wait_drained();

		write_window(WIN_RESET);
		random_frames(100);
		wait_drained();

		$display("checked %0d results, %0d window closes (%0d with a saturated figure)",
			n_checked, n_closed, n_sat);
		$display("covered window lengths 0..65535, counter wrap and idle/stall phases");
		if (errors == 0)
			$display("frame_rate_meter test passed");
		else
			$display("frame_rate_meter test failed");
		$finish;
	end
endmodule

// File: frame_rate_meter.f
+incdir+src
src/frm_pkg.sv
src/frm_if.sv
src/frm_trace_mem.sv
src/frm_div.sv
src/frame_rate_meter.sv
src/frm_checker.sv
tb/frm_tb_if.sv
tb/tb_frame_rate_meter.sv
